>>> hdl/hamming74_bitslice_decoder_defines.svh
// assertion macros used by the checker file
// clock is clk, reset is arst_n (active low) in every user of these macros
`ifndef HAMMING74_BITSLICE_DECODER_DEFINES_SVH
`define HAMMING74_BITSLICE_DECODER_DEFINES_SVH

// same-cycle implication
`define H74BS_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication
`define H74BS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

>>> hdl/h74bs_pkg.sv
// ----------------------------------------------------------------------------
// h74bs_pkg
// shared constants and types of the bit-sliced hamming(7,4) decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package h74bs_pkg;

	localparam int NUM_STREAMS    = 7;
	localparam int NUM_LANES      = 8;
	localparam int BYTES_PER_ITEM = 4;
	localparam int CNT_W          = 32;
	localparam int IDX_W          = $clog2(BYTES_PER_ITEM);

	// one decoded item waiting for the serializer
	typedef struct packed {
		logic [BYTES_PER_ITEM-1:0][7:0] bytes;    // byte 0 goes out first
		logic [IDX_W-1:0]               last_idx; // index of the final byte sent
		logic                           file_end; // final byte hits the budget
	} item_t;

endpackage
`default_nettype wire

>>> hdl/h74bs_lane.sv
// ----------------------------------------------------------------------------
// h74bs_lane
// single-error-correcting decode of one hamming(7,4) codeword
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module h74bs_lane
	import h74bs_pkg::*;
(
	input  wire logic [NUM_STREAMS-1:0] cw,     // bit i is codeword position i+1
	output logic      [3:0]             nibble  // d1 d2 d3 d4, d1 in bit 3
);

	logic [2:0] syn;

	always_comb begin
		syn[0] = cw[0] ^ cw[2] ^ cw[4] ^ cw[6];
		syn[1] = cw[1] ^ cw[2] ^ cw[5] ^ cw[6];
		syn[2] = cw[3] ^ cw[4] ^ cw[5] ^ cw[6];
		// only flips that land on data positions matter for the output
		nibble[3] = cw[2] ^ (syn == 3'd3);
		nibble[2] = cw[4] ^ (syn == 3'd5);
		nibble[1] = cw[5] ^ (syn == 3'd6);
		nibble[0] = cw[6] ^ (syn == 3'd7);
	end

endmodule
`default_nettype wire

>>> hdl/h74bs_front.sv
// ----------------------------------------------------------------------------
// h74bs_front
// eight decode lanes, byte merge, byte budget and the item register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module h74bs_front
	import h74bs_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CNT_W-1:0]         cfg_wdata,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [NUM_STREAMS*8-1:0] in_data,
	input  wire logic                     take,
	output logic                          item_valid,
	output item_t                         item
);

	logic [NUM_LANES-1:0][3:0] nib;
	logic [CNT_W-1:0]          total_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W:0]            diff;
	logic                      live;
	logic                      big;
	logic [2:0]                n_bytes;
	logic                      accept;
	logic                      s1_valid_q;
	item_t                     s1_q;
	item_t                     item_d;

	// lane b gathers bit b of every stream
	for (genvar b = 0; b < NUM_LANES; b++) begin : g_lane
		logic [NUM_STREAMS-1:0] cw;
		for (genvar s = 0; s < NUM_STREAMS; s++) begin : g_bit
			assign cw[s] = in_data[s*8 + b];
		end
		h74bs_lane u_lane (
			.cw     (cw),
			.nibble (nib[b])
		);
	end

	always_comb begin
		diff    = {1'b0, total_q} - {1'b0, count_q};
		live    = !diff[CNT_W] && (diff[CNT_W-1:0] != '0);
		big     = |diff[CNT_W-1:3] || (diff[2:0] > 3'd4);
		n_bytes = (|diff[CNT_W-1:2]) ? 3'd4 : diff[2:0];
		for (int k = 0; k < BYTES_PER_ITEM; k++) begin
			// earlier bit position is the high nibble
			item_d.bytes[k] = {nib[NUM_LANES-1-2*k], nib[NUM_LANES-2-2*k]};
		end
		item_d.last_idx = IDX_W'(n_bytes - 3'd1);
		item_d.file_end = live && !big;
	end

	assign in_ready   = !s1_valid_q || take;
	assign accept     = in_valid && in_ready;
	assign item_valid = s1_valid_q;
	assign item       = s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			count_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (take) begin
				s1_valid_q <= 1'b0;
			end
			// an item past the budget is taken and dropped
			if (accept && live) begin
				count_q    <= count_q + CNT_W'(n_bytes);
				s1_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && live) begin
			s1_q <= item_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/h74bs_ser.sv
// ----------------------------------------------------------------------------
// h74bs_ser
// output register that sends the bytes of one item, one beat each
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module h74bs_ser
	import h74bs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire item_t      item,
	output logic            take,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_data,
	output logic            out_last,
	output logic            out_file_end
);

	logic             busy_q;
	item_t            cur_q;
	logic [IDX_W-1:0] idx_q;
	logic             fire;

	assign out_valid    = busy_q;
	assign out_data     = cur_q.bytes[idx_q];
	assign out_last     = (idx_q == cur_q.last_idx);
	assign out_file_end = out_last && cur_q.file_end;
	assign fire         = busy_q && out_ready;
	// reload on the same edge that the final beat leaves
	assign take         = item_valid && (!busy_q || (fire && out_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= 1'b1;
		end else if (fire && out_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= item;
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> hdl/hamming74_bitslice_decoder.sv
// path: the first byte of an item passes the item register, then the output register
// output: an item sends n bytes (4 when the budget allows) on the one-byte output
//   channel, one beat each, and the next item loads as its final byte leaves; an
//   item past the budget is taken and dropped and sends nothing
// reset: byte count, budget and all valid flags clear asynchronously
// ----------------------------------------------------------------------------
// hamming74_bitslice_decoder
// bit-sliced hamming(7,4) decoder with a running byte budget
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hamming74_bitslice_decoder
	import h74bs_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CNT_W-1:0]         cfg_wdata,      // total_bytes
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// stream0_byte .. stream6_byte, stream0 in the lowest byte
	input  wire logic [NUM_STREAMS*8-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	output logic [7:0]                    m_axis_tdata,   // data_byte
	output logic                          m_axis_tlast,   // last_of_item
	output logic                          m_axis_tuser    // last_of_file
);

	logic  take;
	logic  item_valid;
	item_t item;

	h74bs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	h74bs_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.take         (take),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (m_axis_tdata),
		.out_last     (m_axis_tlast),
		.out_file_end (m_axis_tuser)
	);

endmodule
`default_nettype wire

>>> hdl/h74bs_checker.sv
// ----------------------------------------------------------------------------
// h74bs_checker
// port-level checks of the decoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hamming74_bitslice_decoder_defines.svh"
module h74bs_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     s_axis_tready,
	input wire logic                     m_axis_tvalid,
	input wire logic                     m_axis_tready,
	input wire logic [7:0]               m_axis_tdata,
	input wire logic                     m_axis_tlast,
	input wire logic                     m_axis_tuser
);

	// stalled beat stays up
	`H74BS_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// stalled beat keeps its payload
	`H74BS_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
	// the budget only runs out on the final byte of an item
	`H74BS_ASSERT_NOW(a_file_ends_item, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	// with nothing on the output the input side never stalls
	`H74BS_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

endmodule

bind hamming74_bitslice_decoder h74bs_checker u_h74bs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

>>> tb/tb_hamming74_bitslice_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming74_bitslice_decoder
// the testbench feeds bit-sliced codeword beats and sets the byte budget
// between phases; it decodes every accepted beat on its own, including
// correction and the running budget, and compares each output byte with
// tlast and tuser against the oldest decoded byte still due
// ----------------------------------------------------------------------------
module tb_hamming74_bitslice_decoder;
	import h74bs_pkg::*;

	localparam int DATA_W      = NUM_STREAMS * 8;
	localparam int IDLE_CYCLES = 8;    // item and output registers plus margin
	// longest gap between beats is a few random stalls; far below this
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic       item_end;
		logic       file_end;
	} out_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CNT_W-1:0]  cfg_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;
	logic              m_axis_tlast;
	logic              m_axis_tuser;

	logic [DATA_W-1:0] slice_queue[$];
	out_byte_t         decoded_due[$];
	logic [CNT_W-1:0]  budget = '0;
	logic [CNT_W-1:0]  sent_count = '0;
	bit                calm = 1'b0;
	int                errors = 0;
	int                stalled = 0;

	hamming74_bitslice_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic bit take_break();
		return !calm && ($urandom_range(0, 99) < 20);
	endfunction

	// codeword bit i is position i+1: p1 p2 d1 p4 d2 d3 d4
	function automatic logic [6:0] encode_nibble(input logic [3:0] nib);
		logic d1, d2, d3, d4;
		d1 = nib[3];
		d2 = nib[2];
		d3 = nib[1];
		d4 = nib[0];
		return {d4, d3, d2, d2 ^ d3 ^ d4, d1, d1 ^ d3 ^ d4, d1 ^ d2 ^ d4};
	endfunction

	// codeword of bit position p goes to bit p of every stream byte
	function automatic logic [DATA_W-1:0] pack_slices(input logic [7:0][6:0] cws);
		logic [DATA_W-1:0] d;
		int pos, s;
		d = '0;
		for (pos = 0; pos < 8; pos++)
			for (s = 0; s < NUM_STREAMS; s++)
				d[s*8 + pos] = cws[pos][s];
		return d;
	endfunction

	// mostly valid codewords with zero, one or two flipped bits, some noise
	function automatic logic [DATA_W-1:0] random_item();
		logic [7:0][6:0] cws;
		logic [63:0]     raw;
		int pos, r, a, b;
		if ($urandom_range(0, 9) == 0) begin
			raw = {$urandom, $urandom};
			return raw[DATA_W-1:0];
		end
		for (pos = 0; pos < 8; pos++) begin
			cws[pos] = encode_nibble(4'($urandom_range(0, 15)));
			r = $urandom_range(0, 9);
			a = $urandom_range(0, 6);
			b = (a + $urandom_range(1, 6)) % 7;
			if (r >= 4)
				cws[pos][a] = ~cws[pos][a];
			if (r >= 8)
				cws[pos][b] = ~cws[pos][b];
		end
		return pack_slices(cws);
	endfunction

	// syndrome is the xor of the positions of all set bits
	function automatic logic [3:0] correct_position(input logic [DATA_W-1:0] d,
							input int pos);
		logic [6:0] cw;
		logic [2:0] syn;
		int s;
		syn = '0;
		for (s = 0; s < NUM_STREAMS; s++) begin
			cw[s] = d[s*8 + pos];
			if (cw[s])
				syn ^= 3'(s + 1);
		end
		if (syn != 0)
			cw[syn - 1] = ~cw[syn - 1];
		return {cw[2], cw[4], cw[5], cw[6]};
	endfunction

	task automatic decode_slices(input logic [DATA_W-1:0] d);
		logic [CNT_W-1:0] room;
		out_byte_t        b;
		int n, k;
		room = (sent_count >= budget) ? '0 : budget - sent_count;
		n = (room >= BYTES_PER_ITEM) ? BYTES_PER_ITEM : int'(room);
		for (k = 0; k < n; k++) begin
			sent_count    = sent_count + 1;
			b.data        = {correct_position(d, 7 - 2*k), correct_position(d, 6 - 2*k)};
			b.item_end    = (k == n - 1);
			b.file_end    = (sent_count == budget);
			decoded_due.push_back(b);
		end
	endtask

	// input driver; every accepted beat is decoded here
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				decode_slices(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (slice_queue.size() != 0 && !take_break()) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= slice_queue.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= arst_n && !take_break();
	end

	// output monitor
	always @(posedge clk) begin
		out_byte_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_due.size() == 0) begin
				$display("%0t: unexpected beat data %h last %b user %b", $time,
					m_axis_tdata, m_axis_tlast, m_axis_tuser);
				errors++;
			end else begin
				want = decoded_due.pop_front();
				if (m_axis_tdata !== want.data) begin
					$display("%0t: data expected %h actual %h", $time, want.data,
						m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== want.item_end) begin
					$display("%0t: tlast expected %b actual %b", $time, want.item_end,
						m_axis_tlast);
					errors++;
				end
				if (m_axis_tuser !== want.file_end) begin
					$display("%0t: tuser expected %b actual %b", $time, want.file_end,
						m_axis_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
		    (m_axis_tvalid && m_axis_tready)) begin
			stalled <= 0;
		end else if (stalled >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stalled <= stalled + 1;
		end
	end

	task automatic write_budget(input logic [CNT_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		budget = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sampled at the falling edge so that all beats of the edge have settled
	task automatic wait_idle();
		@(negedge clk);
		while (slice_queue.size() != 0 || s_axis_tvalid || decoded_due.size() != 0)
			@(negedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(input int count);
		int i;
		for (i = 0; i < count; i++)
			slice_queue.push_back(random_item());
	endtask

	initial begin
		logic [7:0][6:0] cws;
		int s, j, pos;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// zero budget: nothing comes out
		write_budget('0);
		queue_random(3);
		wait_idle();

		write_budget('1);
		slice_queue.push_back('0);
		slice_queue.push_back('1);
		// one stream set alone is a single error in that codeword position
		for (s = 0; s < NUM_STREAMS; s++)
			slice_queue.push_back(DATA_W'(8'hff) << (8*s));
		// double error: p1 and p2 flipped, syndrome hits d1
		slice_queue.push_back(DATA_W'(16'hffff));
		slice_queue.push_back({NUM_STREAMS{8'h55}});
		slice_queue.push_back({NUM_STREAMS{8'haa}});
		for (j = 0; j < 2; j++) begin
			for (pos = 0; pos < 8; pos++)
				cws[pos] = encode_nibble(4'(j*8 + 7 - pos));
			slice_queue.push_back(pack_slices(cws));
		end
		queue_random(2);
		wait_idle();

		// budget runs out two bytes into the second beat
		write_budget(sent_count + 6);
		queue_random(4);
		wait_idle();

		// budget below the count keeps output stopped
		write_budget(sent_count - 5);
		queue_random(3);
		wait_idle();

		// a single byte carries both tlast and tuser
		write_budget(sent_count + 1);
		queue_random(2);
		wait_idle();

		write_budget('1);
		calm = 1'b1;
		queue_random(60);
		wait_idle();
		calm = 1'b0;

		queue_random(100);
		wait_idle();

		write_budget(sent_count + CNT_W'($urandom_range(20, 60)));
		queue_random(40);
		wait_idle();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/h74bs_pkg.sv
hdl/h74bs_lane.sv
hdl/h74bs_front.sv
hdl/h74bs_ser.sv
hdl/hamming74_bitslice_decoder.sv
hdl/h74bs_checker.sv
tb/tb_hamming74_bitslice_decoder.sv
